### rtl/arut_pkg.sv
// Package with the shared types and codes of the address range unit table.
package arut_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD_TEMP = 2'd1,
      OP_ADD_PERM = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_DONE = 3'd0,
      ST_EXISTING = 3'd1,
      ST_COLLISION = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      MC_RECENT = 3'd0,
      MC_TEMP_IN = 3'd1,
      MC_PERM_IN = 3'd2,
      MC_TEMP_BEYOND = 3'd3,
      MC_PERM_BEYOND = 3'd4,
      MC_NULL = 3'd5,
      MC_UNKNOWN = 3'd6
   } match_type;

   localparam logic [2:0] KIND_NULL = 3'd0;
   localparam logic [2:0] KIND_UNKNOWN = 3'd1;
   localparam logic [2:0] KIND_CONST = 3'd2;

   localparam logic [12:0] SLACK_RESET = 13'd16;
   localparam logic [15:0] FLOOR_RESET = 16'd1024;

   localparam logic CSR_SLACK = 1'b0;
   localparam logic CSR_FLOOR = 1'b1;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_LK_RECENT,
      S_SCAN_ISSUE,
      S_SCAN_WAIT,
      S_SCAN_EVAL,
      S_SCAN_END,
      S_BEST_READ,
      S_BEST_WAIT,
      S_FREE_WRITE,
      S_TRIM,
      S_RESPOND
   } state_type;

   // Which scan is running.
   typedef enum logic [2:0] {
      SC_T_CONTAIN,
      SC_P_CONTAIN,
      SC_T_BEYOND,
      SC_P_BEYOND,
      SC_T_OVERLAP,
      SC_P_OVERLAP
   } scan_type;

   // One entry as stored in a table.
   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
      logic [31:0] tag;
      logic [2:0] kind;
      logic excess;
   } entry_type;

   function automatic logic overlaps(logic [63:0] al, logic [63:0] ah,
                                     logic [63:0] bl, logic [63:0] bh);
      return ((al <= bl) && (bl < ah)) || ((bl <= al) && (al < bh));
   endfunction

endpackage

### rtl/arut_table.sv
// One range table: entry memory with registered read and flip-flop valid bits.
module arut_table #(
   parameter int ENTRIES = 256,
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input logic clock,
   input logic reset,
   input logic [IW-1:0] rd_index,
   output arut_pkg::entry_type rd_entry,
   output logic rd_valid,
   input logic wr_en,
   input logic [IW-1:0] wr_index,
   input arut_pkg::entry_type wr_entry,
   input logic set_en,
   input logic clr_en,
   input logic [IW-1:0] vld_index,
   output logic [ENTRIES-1:0] valid
);
   import arut_pkg::*;

   entry_type mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_entry;
      end
      rd_entry <= mem[rd_index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid <= 1'b0;
      end else begin
         if (set_en) valid_ff[vld_index] <= 1'b1;
         if (clr_en) valid_ff[vld_index] <= 1'b0;
         rd_valid <= valid_ff[rd_index];
      end
   end

   assign valid = valid_ff;
endmodule

### rtl/address_range_unit_table.sv
// Top level of the address range unit table: sequencer over two range memories.
//
// A request is taken when start is high and busy is low. Opcode lookup maps an
// address to a unit; add temporary, add permanent and remove temporary edit the
// tables. Each request gives one response, shown on the rsp_ ports for one
// cycle with rsp_valid high; the receiver cannot stall, so the response is
// simply presented and dropped.
// Scans: every scan walks the table one entry at a time through the memory's
// registered read port, in the states issue, wait, evaluate and end. A lookup
// costs up to four scans (contain and beyond, both tables) plus a read of the
// best entry. An add permanent of a constant may repeat its overlap scan once
// per trim, up to PERM_ENTRIES + 1 rounds. A free slot is found
// combinationally from the valid bits.
// The user must write the configuration registers beyond_slack and null_floor
// through the csr_ port while no request is in flight; the block does not check.
// Reset empties both tables (valid bits cleared at once), clears the recent
// unit and loads the register reset values; the block is ready in the next
// cycle.
module address_range_unit_table #(
   parameter int TEMP_ENTRIES = 256,
   parameter int PERM_ENTRIES = 256
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_opcode,
   input logic [63:0] req_address,
   input logic [63:0] req_range_low,
   input logic [63:0] req_range_high,
   input logic [2:0] req_unit_kind,
   input logic [31:0] req_unit_tag,
   input logic req_shrink_excess,
   input logic csr_write,
   input logic csr_index,
   input logic [15:0] csr_data,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_match_class,
   output logic [31:0] rsp_found_tag,
   output logic [2:0] rsp_found_kind,
   output logic [63:0] rsp_found_low,
   output logic [63:0] rsp_found_high,
   output logic [63:0] rsp_offset
);
   import arut_pkg::*;

   localparam int TW = (TEMP_ENTRIES > 1) ? $clog2(TEMP_ENTRIES) : 1;
   localparam int PW = (PERM_ENTRIES > 1) ? $clog2(PERM_ENTRIES) : 1;
   localparam int IW = (TW > PW) ? TW : PW;
   localparam int CW = IW + 2;

   // Configuration registers.
   logic [12:0] slack_ff;
   logic [15:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff <= SLACK_RESET;
         floor_ff <= FLOOR_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_SLACK) slack_ff <= csr_data[12:0];
         else floor_ff <= csr_data;
      end
   end

   // Request registers.
   opcode_type op_ff;
   logic [63:0] addr_ff, lo_ff, lo_in, hi_ff, hi_in;
   logic [2:0] kind_ff;
   logic [31:0] tag_ff;
   logic excess_ff;

   // Sequencer registers.
   state_type state_ff, state_in;
   state_type dp_next;
   scan_type scan_ff, scan_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic later_ff, later_in;
   logic best_ok_ff, best_ok_in;
   logic [IW-1:0] best_ff, best_in;
   logic [63:0] best_hi_ff, best_hi_in;
   logic [CW-1:0] round_ff, round_in;

   // Recent unit.
   logic rec_v_ff, rec_v_in;
   logic [63:0] rec_lo_ff, rec_lo_in, rec_hi_ff, rec_hi_in;
   logic [34:0] rec_info_ff, rec_info_in;

   // Response registers.
   logic rv_ff, rv_in;
   logic [2:0] rs_ff, rs_in, rc_ff, rc_in, rk_ff, rk_in;
   logic [31:0] rt_ff, rt_in;
   logic [63:0] rl_ff, rl_in, rh_ff, rh_in, ro_ff, ro_in;

   // Table ports.
   logic [TW-1:0] t_rd, t_vi;
   logic [PW-1:0] p_rd, p_vi;
   entry_type t_q, p_q, wr_e;
   logic t_qv, p_qv;
   logic t_we, p_we, t_set, p_set, t_clr, p_clr;
   logic [TEMP_ENTRIES-1:0] t_valid;
   logic [PERM_ENTRIES-1:0] p_valid;
   logic [IW-1:0] vidx;

   arut_table #(.ENTRIES(TEMP_ENTRIES)) u_temp (
      .clock(clock), .reset(reset), .rd_index(t_rd), .rd_entry(t_q),
      .rd_valid(t_qv), .wr_en(t_we), .wr_index(t_vi), .wr_entry(wr_e),
      .set_en(t_set), .clr_en(t_clr), .vld_index(t_vi), .valid(t_valid));

   arut_table #(.ENTRIES(PERM_ENTRIES)) u_perm (
      .clock(clock), .reset(reset), .rd_index(p_rd), .rd_entry(p_q),
      .rd_valid(p_qv), .wr_en(p_we), .wr_index(p_vi), .wr_entry(wr_e),
      .set_en(p_set), .clr_en(p_clr), .vld_index(p_vi), .valid(p_valid));

   // The scan is on the temporary table for these scans.
   logic on_temp;
   assign on_temp = (scan_ff == SC_T_CONTAIN) || (scan_ff == SC_T_BEYOND) ||
                    (scan_ff == SC_T_OVERLAP);
   entry_type q;
   logic qv;
   assign q = on_temp ? t_q : p_q;
   assign qv = on_temp ? t_qv : p_qv;

   // Index is the last entry of the table under scan (entry count minus one).
   logic last_idx;
   assign last_idx = on_temp ? ({{(IW-TW){1'b0}}, idx_ff[TW-1:0]} ==
                                IW'(TEMP_ENTRIES - 1))
                             : ({{(IW-PW){1'b0}}, idx_ff[PW-1:0]} ==
                                IW'(PERM_ENTRIES - 1));

   // Lowest free slots, found from the valid bits.
   logic t_free_ok, p_free_ok;
   logic [TW-1:0] t_free;
   logic [PW-1:0] p_free;
   always_comb begin
      t_free_ok = 1'b0;
      t_free = '0;
      for (int i = TEMP_ENTRIES - 1; i >= 0; i--) begin
         if (!t_valid[i]) begin
            t_free_ok = 1'b1;
            t_free = TW'(i);
         end
      end
   end
   always_comb begin
      p_free_ok = 1'b0;
      p_free = '0;
      for (int i = PERM_ENTRIES - 1; i >= 0; i--) begin
         if (!p_valid[i]) begin
            p_free_ok = 1'b1;
            p_free = PW'(i);
         end
      end
   end

   // Entry match tests.
   logic contains_hit, overlap_hit;
   assign contains_hit = (q.low <= addr_ff) && (addr_ff < q.high);
   assign overlap_hit = overlaps(q.low, q.high, lo_ff, hi_ff);
   logic [63:0] gap;
   assign gap = addr_ff - best_hi_ff;

   assign t_rd = idx_ff[TW-1:0];
   assign p_rd = idx_ff[PW-1:0];
   assign t_vi = vidx[TW-1:0];
   assign p_vi = vidx[PW-1:0];

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = (req_opcode == OP_LOOKUP) ? S_LK_RECENT
                                                              : S_SCAN_ISSUE;
         S_LK_RECENT, S_SCAN_END, S_BEST_WAIT, S_FREE_WRITE, S_TRIM:
            state_in = state_ff;
         S_SCAN_ISSUE: state_in = S_SCAN_WAIT;
         S_SCAN_WAIT: state_in = S_SCAN_EVAL;
         S_SCAN_EVAL: state_in = S_SCAN_END;
         S_BEST_READ: state_in = S_BEST_WAIT;
         S_RESPOND: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // Data-dependent moves are settled in the datapath block below.
      if (state_ff == S_LK_RECENT || state_ff == S_SCAN_END ||
          state_ff == S_BEST_WAIT || state_ff == S_FREE_WRITE ||
          state_ff == S_TRIM) begin
         state_in = dp_next;
      end
   end

   // Datapath and output logic.
   always_comb begin
      dp_next = S_RESPOND;
      scan_in = scan_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      later_in = later_ff;
      best_ok_in = best_ok_ff;
      best_in = best_ff;
      best_hi_in = best_hi_ff;
      round_in = round_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      rec_v_in = rec_v_ff;
      rec_lo_in = rec_lo_ff;
      rec_hi_in = rec_hi_ff;
      rec_info_in = rec_info_ff;
      rv_in = 1'b0;
      rs_in = rs_ff;
      rc_in = rc_ff;
      rt_in = rt_ff;
      rk_in = rk_ff;
      rl_in = rl_ff;
      rh_in = rh_ff;
      ro_in = ro_ff;
      t_we = 1'b0;
      p_we = 1'b0;
      t_set = 1'b0;
      p_set = 1'b0;
      t_clr = 1'b0;
      p_clr = 1'b0;
      vidx = idx_ff;
      wr_e = '{low: lo_ff, high: hi_ff, tag: tag_ff, kind: kind_ff,
               excess: (op_ff == OP_ADD_TEMP) ? excess_ff : 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            found_in = 1'b0;
            later_in = 1'b0;
            best_ok_in = 1'b0;
            round_in = '0;
            rc_in = MC_RECENT;
            ro_in = '0;
            scan_in = (req_opcode == OP_ADD_PERM) ? SC_T_OVERLAP :
                      (req_opcode == OP_LOOKUP) ? SC_T_CONTAIN : SC_T_OVERLAP;
            if (start) begin
               lo_in = req_range_low;
               hi_in = req_range_high;
            end
         end

         S_LK_RECENT: begin
            rs_in = ST_DONE;
            if (addr_ff == '0) begin
               rc_in = MC_NULL; rt_in = '0; rk_in = KIND_NULL;
               rl_in = '0; rh_in = '0; ro_in = '0;
               dp_next = S_RESPOND;
            end else if (rec_v_ff && rec_lo_ff <= addr_ff && addr_ff < rec_hi_ff) begin
               rc_in = MC_RECENT; rt_in = rec_info_ff[31:0];
               rk_in = rec_info_ff[34:32]; rl_in = rec_lo_ff; rh_in = rec_hi_ff;
               ro_in = (rec_info_ff[34:32] == KIND_NULL ||
                        rec_info_ff[34:32] == KIND_UNKNOWN) ? '0 : addr_ff - rec_lo_ff;
               dp_next = S_RESPOND;
            end else begin
               dp_next = S_SCAN_ISSUE;
            end
         end

         S_SCAN_ISSUE, S_SCAN_WAIT: ;

         S_SCAN_EVAL: begin
            if (qv && !found_ff) begin
               case (scan_ff)
                  SC_T_CONTAIN, SC_P_CONTAIN: if (contains_hit) begin
                     found_in = 1'b1; best_in = idx_ff;
                  end
                  SC_T_OVERLAP, SC_P_OVERLAP: if (overlap_hit) begin
                     found_in = 1'b1; best_in = idx_ff;
                  end
                  default: begin
                     if (q.high > addr_ff) later_in = 1'b1;
                     else if (!best_ok_ff || q.high > best_hi_ff) begin
                        best_ok_in = 1'b1; best_in = idx_ff; best_hi_in = q.high;
                     end
                  end
               endcase
            end
         end

         S_SCAN_END: begin
            if (!found_ff && !last_idx) begin
               idx_in = idx_ff + IW'(1);
               dp_next = S_SCAN_ISSUE;
            end else begin
               idx_in = '0;
               later_in = 1'b0;
               best_ok_in = 1'b0;
               found_in = 1'b0;
               dp_next = S_RESPOND;
               case (scan_ff)
                  SC_T_CONTAIN: begin
                     if (found_ff) dp_next = S_BEST_READ;
                     else begin scan_in = SC_P_CONTAIN; dp_next = S_SCAN_ISSUE; end
                  end
                  SC_P_CONTAIN: begin
                     if (found_ff) dp_next = S_BEST_READ;
                     else begin scan_in = SC_T_BEYOND; dp_next = S_SCAN_ISSUE; end
                  end
                  SC_T_BEYOND, SC_P_BEYOND: begin
                     if (later_ff && best_ok_ff &&
                         gap < {51'd0, slack_ff}) begin
                        found_in = 1'b1; dp_next = S_BEST_READ;
                     end else if (scan_ff == SC_T_BEYOND) begin
                        scan_in = SC_P_BEYOND; dp_next = S_SCAN_ISSUE;
                     end else begin
                        rs_in = ST_DONE; rl_in = '0; rh_in = '0; ro_in = '0;
                        rt_in = '0;
                        if (addr_ff < {48'd0, floor_ff}) begin
                           rc_in = MC_NULL; rk_in = KIND_NULL;
                        end else begin
                           rc_in = MC_UNKNOWN; rk_in = KIND_UNKNOWN;
                        end
                     end
                  end
                  SC_T_OVERLAP: begin
                     if (found_ff) dp_next = S_BEST_READ;
                     else if (op_ff == OP_REMOVE) begin
                        rs_in = ST_NOT_FOUND; rt_in = '0; rk_in = '0;
                        rl_in = '0; rh_in = '0;
                     end else begin
                        scan_in = SC_P_OVERLAP; dp_next = S_SCAN_ISSUE;
                     end
                  end
                  default: begin
                     if (found_ff) dp_next = S_BEST_READ;
                     else dp_next = S_FREE_WRITE;
                  end
               endcase
            end
            // The chosen entry is read back at the index kept in best_ff.
            if (dp_next == S_BEST_READ) idx_in = best_ff;
         end

         S_BEST_READ: ;

         S_BEST_WAIT: begin
            // Entry at best_ff is on the read port now.
            rt_in = q.tag; rk_in = q.kind; rl_in = q.low; rh_in = q.high;
            ro_in = '0;
            vidx = best_ff;
            idx_in = '0;
            dp_next = S_RESPOND;
            case (scan_ff)
               SC_T_CONTAIN, SC_P_CONTAIN, SC_T_BEYOND, SC_P_BEYOND: begin
                  rs_in = ST_DONE;
                  rc_in = (scan_ff == SC_T_CONTAIN) ? MC_TEMP_IN :
                          (scan_ff == SC_P_CONTAIN) ? MC_PERM_IN :
                          (scan_ff == SC_T_BEYOND) ? MC_TEMP_BEYOND : MC_PERM_BEYOND;
                  ro_in = (q.kind == KIND_NULL || q.kind == KIND_UNKNOWN) ? '0
                                                                      : addr_ff - q.low;
                  rec_v_in = 1'b1; rec_lo_in = q.low; rec_hi_in = q.high;
                  rec_info_in = {q.kind, q.tag};
               end
               SC_T_OVERLAP: begin
                  if (op_ff == OP_REMOVE) begin
                     rs_in = ST_DONE;
                     t_clr = 1'b1;
                     if (rec_v_ff && rec_info_ff[31:0] == tag_ff) begin
                        rec_v_in = 1'b0; rec_lo_in = '0; rec_hi_in = '0;
                        rec_info_in = '0;
                     end
                  end else if (op_ff == OP_ADD_PERM) begin
                     rs_in = ST_COLLISION;
                  end else if (q.tag == tag_ff) begin
                     rs_in = ST_EXISTING;
                  end else if (q.excess) begin
                     t_clr = 1'b1;
                     scan_in = SC_P_OVERLAP;
                     dp_next = S_SCAN_ISSUE;
                  end else begin
                     rs_in = ST_COLLISION;
                  end
               end
               default: begin
                  if (op_ff == OP_ADD_TEMP || kind_ff != KIND_CONST ||
                      q.kind != KIND_CONST ||
                      round_ff > CW'(PERM_ENTRIES)) begin
                     rs_in = ST_COLLISION;
                  end else if (lo_ff >= q.low && hi_ff <= q.high) begin
                     rs_in = ST_EXISTING;
                  end else begin
                     dp_next = S_TRIM;
                  end
               end
            endcase
         end

         S_TRIM: begin
            // Constant on constant: drop a covered old range, else cut the lower-starting one.
            vidx = best_ff;
            round_in = round_ff + CW'(1);
            idx_in = '0;
            dp_next = S_SCAN_ISSUE;
            if (rl_ff >= lo_ff && rh_ff <= hi_ff) begin
               p_clr = 1'b1;
            end else if (lo_ff < rl_ff) begin
               hi_in = rl_ff;
            end else begin
               if (rec_v_ff && rec_lo_ff == rl_ff && rec_hi_ff == rh_ff &&
                   rec_info_ff[31:0] == rt_ff) begin
                  rec_hi_in = lo_ff;
               end
               p_we = 1'b1;
               wr_e = '{low: rl_ff, high: lo_ff, tag: rt_ff, kind: rk_ff, excess: 1'b0};
            end
         end

         S_FREE_WRITE: begin
            rt_in = tag_ff; rk_in = kind_ff; rl_in = lo_ff; rh_in = hi_ff;
            dp_next = S_RESPOND;
            if (op_ff == OP_ADD_TEMP) begin
               vidx = {{(IW-TW){1'b0}}, t_free};
               rs_in = t_free_ok ? ST_DONE : ST_FULL;
               t_we = t_free_ok; t_set = t_free_ok;
            end else begin
               vidx = {{(IW-PW){1'b0}}, p_free};
               rs_in = p_free_ok ? ST_DONE : ST_FULL;
               p_we = p_free_ok; p_set = p_free_ok;
            end
         end

         S_RESPOND: rv_in = 1'b1;

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rec_v_ff <= 1'b0;
         rec_lo_ff <= '0;
         rec_hi_ff <= '0;
         rec_info_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rec_v_ff <= rec_v_in;
         rec_lo_ff <= rec_lo_in;
         rec_hi_ff <= rec_hi_in;
         rec_info_ff <= rec_info_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff <= opcode_type'(req_opcode);
         addr_ff <= req_address;
         kind_ff <= req_unit_kind;
         tag_ff <= req_unit_tag;
         excess_ff <= req_shrink_excess;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      scan_ff <= scan_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      later_ff <= later_in;
      best_ok_ff <= best_ok_in;
      best_ff <= best_in;
      best_hi_ff <= best_hi_in;
      round_ff <= round_in;
      rs_ff <= rs_in;
      rc_ff <= rc_in;
      rt_ff <= rt_in;
      rk_ff <= rk_in;
      rl_ff <= rl_in;
      rh_ff <= rh_in;
      ro_ff <= ro_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_match_class = rc_ff;
   assign rsp_found_tag = rt_ff;
   assign rsp_found_kind = rk_ff;
   assign rsp_found_low = rl_ff;
   assign rsp_found_high = rh_ff;
   assign rsp_offset = ro_ff;
endmodule

### rtl/arut_checker.sv
// Port-level checker for the address range unit table, with its bind.
module arut_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic [2:0] rsp_status,
   input logic [2:0] rsp_match_class,
   input logic [63:0] rsp_offset
);
   import arut_pkg::*;

   // A taken request makes the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");

   // A response ends the request.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");

   // Responses are single-cycle strobes.
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");

   // Null and unknown answers carry no offset.
   a_null_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_match_class == MC_NULL || rsp_match_class == MC_UNKNOWN))
      |-> (rsp_offset == '0)) else $error("offset on null");

   // A status code stays within the defined set.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FULL)) else $error("bad status");
endmodule

bind address_range_unit_table arut_checker u_arut_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_match_class(rsp_match_class), .rsp_offset(rsp_offset));

### test/testbench.sv
// Self-checking testbench for the address range unit table.
`timescale 1ns / 1ps

module testbench;
   import arut_pkg::*;

   localparam int TABLE_DEPTH = 256;
   // Stop the run here if it has not ended by then; the limit leaves a wide
   // margin for long trim passes.
   localparam longint CYCLE_LIMIT = 40_000_000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_opcode;
   logic [63:0] req_address;
   logic [63:0] req_range_low;
   logic [63:0] req_range_high;
   logic [2:0] req_unit_kind;
   logic [31:0] req_unit_tag;
   logic req_shrink_excess;
   logic csr_write;
   logic csr_index;
   logic [15:0] csr_data;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [2:0] rsp_match_class;
   logic [31:0] rsp_found_tag;
   logic [2:0] rsp_found_kind;
   logic [63:0] rsp_found_low;
   logic [63:0] rsp_found_high;
   logic [63:0] rsp_offset;

   address_range_unit_table DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_address(req_address),
      .req_range_low(req_range_low),
      .req_range_high(req_range_high),
      .req_unit_kind(req_unit_kind),
      .req_unit_tag(req_unit_tag),
      .req_shrink_excess(req_shrink_excess),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_match_class(rsp_match_class),
      .rsp_found_tag(rsp_found_tag),
      .rsp_found_kind(rsp_found_kind),
      .rsp_found_low(rsp_found_low),
      .rsp_found_high(rsp_found_high),
      .rsp_offset(rsp_offset)
   );

   // What the driver does next: send a request, write a register once the
   // block is idle, or simply hold off until every response is back.
   typedef enum logic [1:0] {
      JOB_REQUEST,
      JOB_CSR,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type act;
      opcode_type opcode;
      logic [63:0] address;
      logic [63:0] range_low;
      logic [63:0] range_high;
      logic [2:0] unit_kind;
      logic [31:0] unit_tag;
      logic shrink_excess;
      logic reg_index;
      logic [15:0] reg_value;
      int gap;
   } job_type;

   typedef struct {
      status_type status;
      match_type match_class;
      logic [31:0] tag;
      logic [2:0] kind;
      logic [63:0] low;
      logic [63:0] high;
      logic [63:0] offset;
   } answer_type;

   typedef struct {
      logic valid;
      logic [63:0] low;
      logic [63:0] high;
      logic [31:0] tag;
      logic [2:0] kind;
      logic excess;
   } range_entry_type;

   // Shadow copy of the block's state.
   range_entry_type temp_ranges[TABLE_DEPTH];
   range_entry_type perm_ranges[TABLE_DEPTH];
   range_entry_type last_hit;
   logic [12:0] slack_reg;
   logic [15:0] floor_reg;

   job_type pending_jobs[$];
   answer_type expected_answers[$];

   logic req_taken;
   int wait_cycles;
   int error_count;
   longint cycle_count;
   int requests_sent;
   int status_seen[5];
   int class_seen[7];
   logic burst_mode;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic logic ranges_meet(logic [63:0] al, logic [63:0] ah,
                                        logic [63:0] bl, logic [63:0] bh);
      return ((al <= bl) && (bl < ah)) || ((bl <= al) && (al < bh));
   endfunction

   function automatic answer_type make_answer(status_type st, match_type mc,
                                              range_entry_type e, logic [63:0] off);
      answer_type r;
      r.status = st;
      r.match_class = mc;
      r.tag = e.tag;
      r.kind = e.kind;
      r.low = e.low;
      r.high = e.high;
      r.offset = off;
      return r;
   endfunction

   function automatic int first_overlap(logic is_perm, logic [63:0] lo, logic [63:0] hi);
      range_entry_type e;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         e = is_perm ? perm_ranges[i] : temp_ranges[i];
         if (e.valid && ranges_meet(e.low, e.high, lo, hi)) return i;
      end
      return -1;
   endfunction

   function automatic int first_holder(logic is_perm, logic [63:0] a);
      range_entry_type e;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         e = is_perm ? perm_ranges[i] : temp_ranges[i];
         if (e.valid && e.low <= a && a < e.high) return i;
      end
      return -1;
   endfunction

   // Nearest range ending at or below the address, used only when some range
   // of the same table ends above it and the gap is under the slack.
   function automatic int nearest_below(logic is_perm, logic [63:0] a);
      range_entry_type e;
      logic later;
      int best;
      logic [63:0] best_high;
      later = 1'b0;
      best = -1;
      best_high = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         e = is_perm ? perm_ranges[i] : temp_ranges[i];
         if (e.valid) begin
            if (e.high > a) later = 1'b1;
            else if (best < 0 || e.high > best_high) begin
               best = i;
               best_high = e.high;
            end
         end
      end
      if (!later || best < 0) return -1;
      if (a - best_high < {51'd0, slack_reg}) return best;
      return -1;
   endfunction

   function automatic answer_type hit_unit(match_type mc, logic [63:0] a, range_entry_type e);
      logic [63:0] off;
      off = (e.kind == KIND_NULL || e.kind == KIND_UNKNOWN) ? 64'd0 : a - e.low;
      if (mc != MC_RECENT) begin
         last_hit = e;
         last_hit.valid = 1'b1;
         last_hit.excess = 1'b0;
      end
      return make_answer(ST_DONE, mc, e, off);
   endfunction

   function automatic answer_type resolve_address(logic [63:0] a);
      range_entry_type none;
      int i;
      none = '{default: '0};
      if (a == 64'd0) return make_answer(ST_DONE, MC_NULL, none, 64'd0);
      if (last_hit.valid && last_hit.low <= a && a < last_hit.high)
         return hit_unit(MC_RECENT, a, last_hit);
      i = first_holder(1'b0, a);
      if (i >= 0) return hit_unit(MC_TEMP_IN, a, temp_ranges[i]);
      i = first_holder(1'b1, a);
      if (i >= 0) return hit_unit(MC_PERM_IN, a, perm_ranges[i]);
      i = nearest_below(1'b0, a);
      if (i >= 0) return hit_unit(MC_TEMP_BEYOND, a, temp_ranges[i]);
      i = nearest_below(1'b1, a);
      if (i >= 0) return hit_unit(MC_PERM_BEYOND, a, perm_ranges[i]);
      if (a < {48'd0, floor_reg}) return make_answer(ST_DONE, MC_NULL, none, 64'd0);
      none.kind = KIND_UNKNOWN;
      return make_answer(ST_DONE, MC_UNKNOWN, none, 64'd0);
   endfunction

   function automatic answer_type insert_temp(range_entry_type n);
      int i;
      i = first_overlap(1'b0, n.low, n.high);
      if (i >= 0) begin
         if (temp_ranges[i].tag == n.tag)
            return make_answer(ST_EXISTING, MC_RECENT, temp_ranges[i], 64'd0);
         // A leftover from a shrinking realloc gives way to the new unit.
         if (temp_ranges[i].excess) temp_ranges[i].valid = 1'b0;
         else return make_answer(ST_COLLISION, MC_RECENT, temp_ranges[i], 64'd0);
      end
      i = first_overlap(1'b1, n.low, n.high);
      if (i >= 0) return make_answer(ST_COLLISION, MC_RECENT, perm_ranges[i], 64'd0);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (!temp_ranges[k].valid) begin
            temp_ranges[k] = n;
            temp_ranges[k].valid = 1'b1;
            return make_answer(ST_DONE, MC_RECENT, n, 64'd0);
         end
      end
      return make_answer(ST_FULL, MC_RECENT, n, 64'd0);
   endfunction

   function automatic answer_type insert_perm(range_entry_type n);
      int i;
      range_entry_type c;
      n.excess = 1'b0;
      i = first_overlap(1'b0, n.low, n.high);
      if (i >= 0) return make_answer(ST_COLLISION, MC_RECENT, temp_ranges[i], 64'd0);
      for (int pass = 0; ; pass++) begin
         i = first_overlap(1'b1, n.low, n.high);
         if (i < 0) break;
         c = perm_ranges[i];
         if (n.kind != KIND_CONST || c.kind != KIND_CONST || pass > TABLE_DEPTH)
            return make_answer(ST_COLLISION, MC_RECENT, c, 64'd0);
         if (n.low >= c.low && n.high <= c.high)
            return make_answer(ST_EXISTING, MC_RECENT, c, 64'd0);
         else if (c.low >= n.low && c.high <= n.high)
            perm_ranges[i].valid = 1'b0;
         else if (n.low < c.low)
            n.high = c.low;
         else begin
            // The older constant is cut back; the recent unit follows it.
            if (last_hit.valid && last_hit.low == c.low && last_hit.high == c.high &&
                last_hit.tag == c.tag)
               last_hit.high = n.low;
            perm_ranges[i].high = n.low;
         end
      end
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (!perm_ranges[k].valid) begin
            perm_ranges[k] = n;
            perm_ranges[k].valid = 1'b1;
            return make_answer(ST_DONE, MC_RECENT, n, 64'd0);
         end
      end
      return make_answer(ST_FULL, MC_RECENT, n, 64'd0);
   endfunction

   function automatic answer_type drop_temp(logic [63:0] lo, logic [63:0] hi, logic [31:0] tag);
      int i;
      range_entry_type none;
      none = '{default: '0};
      i = first_overlap(1'b0, lo, hi);
      if (i < 0) return make_answer(ST_NOT_FOUND, MC_RECENT, none, 64'd0);
      if (last_hit.valid && last_hit.tag == tag) last_hit = '{default: '0};
      temp_ranges[i].valid = 1'b0;
      return make_answer(ST_DONE, MC_RECENT, temp_ranges[i], 64'd0);
   endfunction

   function automatic answer_type predict_request();
      range_entry_type n;
      n.valid = 1'b1;
      n.low = req_range_low;
      n.high = req_range_high;
      n.tag = req_unit_tag;
      n.kind = req_unit_kind;
      n.excess = req_shrink_excess;
      case (opcode_type'(req_opcode))
         OP_LOOKUP: return resolve_address(req_address);
         OP_ADD_TEMP: return insert_temp(n);
         OP_ADD_PERM: return insert_perm(n);
         default: return drop_temp(req_range_low, req_range_high, req_unit_tag);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driver: all inputs change on the falling edge.
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      logic next_start;
      logic next_write;
      job_type j;
      next_start = start;
      next_write = 1'b0;
      if (!reset) begin
         if (start && req_taken) next_start = 1'b0;
         if (!next_start) begin
            if (wait_cycles > 0) wait_cycles <= wait_cycles - 1;
            else if (pending_jobs.size() > 0) begin
               j = pending_jobs[0];
               case (j.act)
                  JOB_REQUEST: begin
                     req_opcode <= j.opcode;
                     req_address <= j.address;
                     req_range_low <= j.range_low;
                     req_range_high <= j.range_high;
                     req_unit_kind <= j.unit_kind;
                     req_unit_tag <= j.unit_tag;
                     req_shrink_excess <= j.shrink_excess;
                     next_start = 1'b1;
                     wait_cycles <= j.gap;
                     void'(pending_jobs.pop_front());
                  end
                  JOB_CSR: begin
                     // Registers change only with the block idle and nothing owed.
                     if (expected_answers.size() == 0 && !busy && !start) begin
                        csr_index <= j.reg_index;
                        csr_data <= j.reg_value;
                        next_write = 1'b1;
                        void'(pending_jobs.pop_front());
                     end
                  end
                  default: begin
                     if (expected_answers.size() == 0 && !busy && !start)
                        void'(pending_jobs.pop_front());
                  end
               endcase
            end
         end
      end
      start <= next_start;
      csr_write <= next_write;
   end

   // ---------------------------------------------------------------------
   // Monitor: sample on the rising edge, predict accepted requests and
   // check each response against the oldest prediction.
   // ---------------------------------------------------------------------

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: response with none expected, expected none, actual status %0d",
                        $time, rsp_status);
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("match_class", want.match_class, rsp_match_class);
               check_field("found_tag", want.tag, rsp_found_tag);
               check_field("found_kind", want.kind, rsp_found_kind);
               check_field("found_low", want.low, rsp_found_low);
               check_field("found_high", want.high, rsp_found_high);
               check_field("offset", want.offset, rsp_offset);
            end
         end
         if (start && !busy) begin
            want = predict_request();
            expected_answers.push_back(want);
            status_seen[want.status]++;
            if (opcode_type'(req_opcode) == OP_LOOKUP) class_seen[want.match_class]++;
            requests_sent++;
            req_taken <= 1'b1;
         end else begin
            req_taken <= 1'b0;
         end
         if (csr_write) begin
            if (csr_index == CSR_SLACK) slack_reg = csr_data[12:0];
            else floor_reg = csr_data;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic int draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic void queue_request(opcode_type op, logic [63:0] addr, logic [63:0] lo,
                                         logic [63:0] hi, logic [2:0] kind,
                                         logic [31:0] tag, logic excess);
      job_type j;
      j.act = JOB_REQUEST;
      j.opcode = op;
      j.address = addr;
      j.range_low = lo;
      j.range_high = hi;
      j.unit_kind = kind;
      j.unit_tag = tag;
      j.shrink_excess = excess;
      j.reg_index = CSR_SLACK;
      j.reg_value = '0;
      j.gap = draw_gap();
      pending_jobs.push_back(j);
   endfunction

   function automatic void queue_control(job_kind_type act, logic idx, logic [15:0] value);
      job_type j;
      j = '{act: JOB_REQUEST, opcode: OP_LOOKUP, default: '0};
      j.act = act;
      j.opcode = OP_LOOKUP;
      j.reg_index = idx;
      j.reg_value = value;
      pending_jobs.push_back(j);
   endfunction

   function automatic logic [63:0] wide_random();
      return {$urandom(), $urandom()};
   endfunction

   // Random content for the busy address window, so ranges meet and trim often.
   function automatic void queue_random_request();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] addr;
      logic [2:0] kind;
      logic [31:0] tag;
      int pick;
      lo = 64'h1000 + $urandom_range(0, 4095);
      hi = lo + $urandom_range(1, 64);
      if ($urandom_range(0, 49) == 0) begin
         lo = wide_random();
         hi = wide_random();
      end
      pick = $urandom_range(0, 19);
      if (pick < 13) addr = 64'h1000 + $urandom_range(0, 4200);
      else if (pick < 15) addr = $urandom_range(0, 2047);
      else if (pick < 16) addr = 64'd0;
      else addr = wide_random();
      kind = $urandom_range(0, 5);
      tag = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 45)
         queue_request(OP_LOOKUP, addr, wide_random(), wide_random(), kind, $urandom(),
                       1'($urandom()));
      else if (pick < 65)
         queue_request(OP_ADD_TEMP, wide_random(), lo, hi, kind, tag,
                       $urandom_range(0, 3) == 0);
      else if (pick < 85)
         queue_request(OP_ADD_PERM, wide_random(), lo, hi,
                       ($urandom_range(0, 2) != 0) ? KIND_CONST : kind, tag, 1'($urandom()));
      else
         queue_request(OP_REMOVE, wide_random(), lo, hi, kind, tag, 1'($urandom()));
   endfunction

   initial begin
      logic [15:0] slack_pick[4];
      logic [15:0] floor_pick[4];
      reset = 1'b1;
      start = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_SLACK;
      csr_data = '0;
      req_opcode = OP_LOOKUP;
      req_address = '0;
      req_range_low = '0;
      req_range_high = '0;
      req_unit_kind = '0;
      req_unit_tag = '0;
      req_shrink_excess = 1'b0;
      req_taken = 1'b0;
      wait_cycles = 0;
      error_count = 0;
      cycle_count = 0;
      requests_sent = 0;
      burst_mode = 1'b0;
      status_seen = '{default: 0};
      class_seen = '{default: 0};
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         temp_ranges[i] = '{default: '0};
         perm_ranges[i] = '{default: '0};
      end
      last_hit = '{default: '0};
      slack_reg = SLACK_RESET;
      floor_reg = FLOOR_RESET;

      // Directed requests under the reset register values.
      queue_request(OP_LOOKUP, 64'd0, '0, '0, '0, '0, 1'b0);
      queue_request(OP_LOOKUP, '1, '1, '1, 3'd7, '1, 1'b1);
      queue_request(OP_LOOKUP, 64'd500, '0, '0, '0, '0, 1'b0);
      queue_request(OP_ADD_TEMP, '0, 64'h1000, 64'h1040, 3'd5, 32'd1, 1'b0);
      queue_request(OP_ADD_TEMP, '0, 64'h1020, 64'h1080, 3'd4, 32'd1, 1'b0);
      queue_request(OP_ADD_TEMP, '0, 64'h1030, 64'h1050, 3'd4, 32'd2, 1'b0);
      queue_request(OP_ADD_TEMP, '0, 64'h2000, 64'h2010, 3'd5, 32'd3, 1'b1);
      queue_request(OP_ADD_TEMP, '0, 64'h2008, 64'h2020, 3'd5, 32'd4, 1'b0);
      queue_request(OP_ADD_PERM, '0, 64'h3000, 64'h3100, KIND_CONST, 32'd5, 1'b0);
      queue_request(OP_ADD_PERM, '0, 64'h3010, 64'h3020, KIND_CONST, 32'd6, 1'b0);
      queue_request(OP_LOOKUP, 64'h3050, '0, '0, '0, '0, 1'b0);
      queue_request(OP_ADD_PERM, '0, 64'h3080, 64'h3300, KIND_CONST, 32'd7, 1'b0);
      queue_request(OP_LOOKUP, 64'h3070, '0, '0, '0, '0, 1'b0);
      queue_request(OP_ADD_PERM, '0, 64'h2F00, 64'h3400, KIND_CONST, 32'd8, 1'b0);
      queue_request(OP_ADD_PERM, '0, 64'h2E00, 64'h2F80, KIND_CONST, 32'd9, 1'b0);
      queue_request(OP_ADD_PERM, '0, 64'h2E10, 64'h2E20, 3'd3, 32'd10, 1'b0);
      queue_request(OP_ADD_PERM, '0, 64'h1000, 64'h1004, KIND_CONST, 32'd11, 1'b0);
      queue_request(OP_ADD_TEMP, '0, 64'h3000, 64'h3004, 3'd4, 32'd12, 1'b0);
      queue_request(OP_LOOKUP, 64'h1010, '0, '0, '0, '0, 1'b0);
      queue_request(OP_LOOKUP, 64'h1011, '0, '0, '0, '0, 1'b0);
      queue_request(OP_LOOKUP, 64'h1045, '0, '0, '0, '0, 1'b0);
      queue_request(OP_LOOKUP, 64'h3405, '0, '0, '0, '0, 1'b0);
      queue_request(OP_LOOKUP, 64'h7FFFF, '0, '0, '0, '0, 1'b0);
      queue_request(OP_REMOVE, '0, 64'h1000, 64'h1001, '0, 32'd1, 1'b0);
      queue_request(OP_REMOVE, '0, 64'h9000, 64'h9001, '0, 32'd1, 1'b0);

      // Register settings per phase: three fixed ones first, then random ones.
      slack_pick = '{16'd0, 16'd4096, 16'd8191, 16'($urandom_range(1, 64))};
      floor_pick = '{16'd0, 16'hFFFF, 16'd1024, 16'($urandom_range(1, 8000))};
      for (int phase = 0; phase < 4; phase++) begin
         queue_control(JOB_CSR, CSR_SLACK, slack_pick[phase]);
         queue_control(JOB_CSR, CSR_FLOOR, floor_pick[phase]);
         for (int n = 0; n < 130; n++) begin
            if (n % 30 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            // Mid-phase the sender holds off until the block has caught up.
            if (n == 65) queue_control(JOB_DRAIN, CSR_SLACK, '0);
            queue_random_request();
         end
      end

      // Fill the temporary table past its end, then probe and empty part of it.
      burst_mode = 1'b1;
      for (int n = 0; n < 260; n++)
         queue_request(OP_ADD_TEMP, wide_random(), 64'h100000 + 64'(n) * 16,
                       64'h100000 + 64'(n) * 16 + 8, 3'd5, 32'h8000_0000 + n, 1'b0);
      burst_mode = 1'b0;
      for (int n = 0; n < 20; n++)
         queue_request(OP_REMOVE, '0, 64'h100000 + 64'($urandom_range(0, 259)) * 16 + 4,
                       64'h100000 + 64'($urandom_range(0, 259)) * 16 + 5, '0,
                       32'h8000_0000 + n, 1'b0);
      for (int n = 0; n < 20; n++) queue_random_request();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for all requests to be taken and answered, then let the block settle.
      wait (pending_jobs.size() == 0 && !start && expected_answers.size() == 0);
      repeat (50) @(posedge clock);

      $display("Covered %0d requests over five register settings; statuses done/existing/",
               requests_sent);
      $display("collision/not found/full = %0d/%0d/%0d/%0d/%0d, lookups null %0d unknown %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], class_seen[MC_NULL], class_seen[MC_UNKNOWN]);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
